// File: rtl/cbs_pkg.sv
// Shared types, packet codes and the CRC-16 byte update for the CAN buffer segmenter.
// No dependencies; every other file of the block imports this package.
package cbs_pkg;

    // One payload byte with its framing side information.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic [7:0] dest_node;
        logic [7:0] send_mode;
    } in_item_t;

    // One CAN frame.
    typedef struct packed {
        logic [15:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  data_0;
        logic [7:0]  data_1;
        logic [7:0]  data_2;
        logic [7:0]  data_3;
        logic [7:0]  data_4;
        logic [7:0]  data_5;
        logic [7:0]  data_6;
        logic [7:0]  data_7;
        logic        run_last;
    } out_item_t;

    // Packet codes placed in the upper byte of the frame id.
    localparam logic [7:0] CODE_FILL      = 8'd5;
    localparam logic [7:0] CODE_FILL_LONG = 8'd6;
    localparam logic [7:0] CODE_PROCESS   = 8'd7;
    localparam logic [7:0] CODE_SHORT     = 8'd8;

    // Group sizes and the limits of the payload.
    localparam int          GROUP_DEPTH   = 7;
    localparam logic [2:0]  GROUP_SHORT   = 3'd7;
    localparam logic [2:0]  GROUP_LONG    = 3'd6;
    localparam logic [15:0] SHORT_MAX     = 16'd6;
    localparam logic [15:0] BYTE_LIMIT    = 16'hFFFF;

    // CRC-16 polynomial (XMODEM form).
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration port.
    localparam int         APB_ADDR_W      = 3;
    localparam logic [0:0] REG_OWN_NODE_ID = 1'b0;

    // One byte through the CRC, most significant bit first.
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/cbs_core.sv
// Segmenting core: byte count, fill group, running CRC and latched header fields,
// and the combinational build of the up to two frames one byte produces. Uses cbs_pkg.
module cbs_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbs_pkg::in_item_t item,
    input  logic              step,
    input  logic [7:0]        own_node_id,
    output logic [1:0]        frame_cnt,
    output cbs_pkg::out_item_t frame_a,
    output cbs_pkg::out_item_t frame_b
);
    import cbs_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [2:0]  group_fill_reg, group_fill_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  group_reg [GROUP_DEPTH];
    logic [7:0]  group_next [GROUP_DEPTH];

    logic        accepted;
    logic [2:0]  wr_idx;
    logic [15:0] count_inc;
    logic [2:0]  fill_inc;
    logic [15:0] crc_upd;
    logic [15:0] start;
    logic        start_low;
    logic        flush_now;
    logic [3:0]  fl_len;
    logic [7:0]  fl_code;
    logic [7:0][7:0] fl_d;
    logic [7:0][7:0] sh_d;
    logic [7:0][7:0] cl_d;
    out_item_t   fl_frame;
    out_item_t   sh_frame;
    out_item_t   cl_frame;

    // Builds a frame; data bytes at or past the length read as zero.
    function automatic out_item_t make_frame(logic [7:0] code, logic [7:0] dest,
                                             logic [3:0] len, logic [7:0][7:0] d,
                                             logic last);
        out_item_t       f;
        logic [7:0][7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (4'(i) < len) ? d[i] : 8'h00;
        end
        f.frame_id  = {code, dest};
        f.frame_len = len;
        f.data_0    = m[0];
        f.data_1    = m[1];
        f.data_2    = m[2];
        f.data_3    = m[3];
        f.data_4    = m[4];
        f.data_5    = m[5];
        f.data_6    = m[6];
        f.data_7    = m[7];
        f.run_last  = last;
        return f;
    endfunction

    always_comb begin
        accepted  = (byte_count_reg != BYTE_LIMIT);
        dest_next = (byte_count_reg == '0) ? item.dest_node : dest_reg;
        mode_next = (byte_count_reg == '0) ? item.send_mode : mode_reg;
        crc_upd   = accepted ? crc_byte(crc_reg, item.payload_byte) : crc_reg;
        count_inc = accepted ? byte_count_reg + 16'd1 : byte_count_reg;
        fill_inc  = accepted ? group_fill_reg + 3'd1 : group_fill_reg;
        // A full group is always sent, so the fill never reaches seven here.
        wr_idx    = (group_fill_reg == GROUP_SHORT) ? 3'd0 : group_fill_reg;
        for (int j = 0; j < GROUP_DEPTH; j++) begin
            group_next[j] = (accepted && wr_idx == 3'(j)) ? item.payload_byte
                                                          : group_reg[j];
        end

        // Fill frame for the group as it stands after this byte.
        start     = count_inc - {13'd0, fill_inc};
        start_low = (start[15:8] == 8'd0);
        fl_d      = '0;
        if (start_low) begin
            fl_code = CODE_FILL;
            fl_len  = {1'b0, fill_inc} + 4'd1;
            fl_d[0] = start[7:0];
            for (int i = 1; i < 8; i++) begin
                fl_d[i] = group_next[i - 1];
            end
        end else begin
            fl_code = CODE_FILL_LONG;
            fl_len  = ((fill_inc > GROUP_LONG) ? {1'b0, GROUP_LONG} : {1'b0, fill_inc})
                      + 4'd2;
            fl_d[0] = start[15:8];
            fl_d[1] = start[7:0];
            for (int i = 2; i < 8; i++) begin
                fl_d[i] = group_next[i - 2];
            end
        end

        sh_d    = '0;
        sh_d[0] = own_node_id;
        sh_d[1] = mode_next;
        for (int i = 2; i < 8; i++) begin
            sh_d[i] = group_next[i - 2];
        end

        cl_d    = '0;
        cl_d[0] = own_node_id;
        cl_d[1] = mode_next;
        cl_d[2] = count_inc[15:8];
        cl_d[3] = count_inc[7:0];
        cl_d[4] = crc_upd[15:8];
        cl_d[5] = crc_upd[7:0];

        flush_now = !item.last_byte && accepted && (count_inc >= 16'd7) &&
                    (fill_inc >= (start_low ? GROUP_SHORT : GROUP_LONG));

        fl_frame = make_frame(fl_code, dest_next, fl_len, fl_d, 1'b0);
        sh_frame = make_frame(CODE_SHORT, dest_next, count_inc[3:0] + 4'd2, sh_d, 1'b1);
        cl_frame = make_frame(CODE_PROCESS, dest_next, 4'd6, cl_d, 1'b1);

        frame_b = cl_frame;
        if (item.last_byte) begin
            if (count_inc <= SHORT_MAX) begin
                frame_cnt = 2'd1;
                frame_a   = sh_frame;
            end else if (fill_inc != 3'd0) begin
                frame_cnt = 2'd2;
                frame_a   = fl_frame;
            end else begin
                frame_cnt = 2'd1;
                frame_a   = cl_frame;
            end
        end else if (flush_now) begin
            frame_cnt = 2'd1;
            frame_a   = fl_frame;
            frame_a.run_last = 1'b1;
        end else begin
            frame_cnt = 2'd0;
            frame_a   = fl_frame;
        end

        if (item.last_byte) begin
            byte_count_next = '0;
            group_fill_next = '0;
            crc_next        = '0;
        end else begin
            byte_count_next = count_inc;
            group_fill_next = flush_now ? 3'd0 : fill_inc;
            crc_next        = crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            group_fill_reg <= '0;
            crc_reg        <= '0;
            dest_reg       <= '0;
            mode_reg       <= '0;
        end else if (step) begin
            byte_count_reg <= byte_count_next;
            group_fill_reg <= group_fill_next;
            crc_reg        <= crc_next;
            dest_reg       <= dest_next;
            mode_reg       <= mode_next;
        end
    end

    // Group bytes are only read once written for the current group.
    always_ff @(posedge aclk) begin
        if (step) begin
            group_reg <= group_next;
        end
    end

endmodule

// File: rtl/can_buffer_segmenter_crc16_top.sv
// Top level of the CAN buffer segmenter: input register, segmenting core, two-frame
// output buffer and the APB register port. Depends on cbs_pkg and cbs_core.
//
// Usage: payload bytes enter on the s_ channel one word per cycle, with the last
// byte flagged; the destination node and send mode are taken from the first byte.
// Frames leave on the m_ channel. A payload of up to six bytes gives one short frame
// on its last byte; a longer one gives a fill frame for every full group of seven
// (six past start index 255) bytes and, on the last byte, the remaining partial group
// and a closing frame with length and CRC-16. run_last marks the final frame of a byte.
// An accepted byte is held in the input register; the core builds its frames, which are
// registered into the output buffer that drives m_valid and m_data.
// Throughput: one byte per cycle while its frames fit; the last byte of a payload can
// produce two frames, which leave through the two-entry output buffer.
// When the receiver stalls, bytes that produce no frame still pass; a byte whose frames
// do not fit in the output buffer waits in the input register, and s_ready drops.
// own_node_id is written at byte address 0 of the APB port and should change only
// while the block is idle.
// Reset (aresetn low at a clock edge) clears the counters, CRC, latched header bytes,
// own_node_id and both buffers; no initialization sequence follows.
module can_buffer_segmenter_crc16_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cbs_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output cbs_pkg::out_item_t                m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import cbs_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic [7:0] own_node_id_reg;

    logic [1:0] count_reg, count_next;
    out_item_t  slot_reg [2];
    out_item_t  slot_next [2];

    logic       advance;
    logic       pop;
    logic [1:0] count_after;
    logic       fits;
    logic [1:0] frame_cnt;
    out_item_t  frame_a;
    out_item_t  frame_b;

    cbs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item        (in_item_reg),
        .step        (advance),
        .own_node_id (own_node_id_reg),
        .frame_cnt   (frame_cnt),
        .frame_a     (frame_a),
        .frame_b     (frame_b)
    );

    // APB register port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OWN_NODE_ID) ? {24'd0, own_node_id_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_node_id_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_OWN_NODE_ID) begin
            own_node_id_reg <= pwdata[7:0];
        end
    end

    // The item in the input register moves on once its frames fit behind the ones
    // still waiting, counting the one leaving this cycle.
    assign m_valid     = (count_reg != 2'd0);
    assign m_data      = slot_reg[0];
    assign pop         = m_valid && m_ready;
    assign count_after = count_reg - {1'b0, pop};
    assign fits        = (frame_cnt == 2'd0) || (count_after == 2'd0) ||
                         (count_after == 2'd1 && frame_cnt == 2'd1);
    assign advance     = in_valid_reg && fits;
    assign s_ready     = !in_valid_reg || advance;

    always_comb begin
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        count_next   = count_after;
        if (advance && frame_cnt != 2'd0) begin
            if (count_after == 2'd0) begin
                slot_next[0] = frame_a;
                slot_next[1] = frame_b;
            end else begin
                slot_next[1] = frame_a;
            end
            count_next = count_after + frame_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        slot_reg <= slot_next;
    end

endmodule

// File: tb/can_buffer_segmenter_crc16_top_test.sv
// Self-checking testbench for can_buffer_segmenter_crc16_top: drives payload bytes and
// own_node_id writes, predicts every CAN frame and compares it with the m_ channel.
// Depends on cbs_pkg and the RTL of the block.
module can_buffer_segmenter_crc16_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbs_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [APB_ADDR_W-1:0] OWN_ID_ADDR = APB_ADDR_W'(4 * REG_OWN_NODE_ID);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Segmenter state as the predictor sees it.
    logic [15:0] seg_count = '0;
    logic [7:0]  seg_group [7];
    logic [2:0]  seg_fill = '0;
    logic [15:0] seg_crc = '0;
    logic [7:0]  seg_dest = '0;
    logic [7:0]  seg_mode = '0;
    logic [7:0]  own_id = '0;

    out_item_t step_frames [$];
    out_item_t expected_frames [$];

    int error_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;

    can_buffer_segmenter_crc16_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("can_buffer_segmenter_crc16_top test failed");
            $finish;
        end
    end

    // Bitwise CRC-16, data shifted in most significant bit first.
    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ 16'h1021;
            end
        end
        return r;
    endfunction

    // Data byte 0 sits in d[63:56]; bytes past n are already zero in d.
    function automatic out_item_t build_frame(logic [7:0] code, logic [63:0] d, int n);
        out_item_t f;
        f.frame_id  = {code, seg_dest};
        f.frame_len = n[3:0];
        f.data_0    = d[63:56];
        f.data_1    = d[55:48];
        f.data_2    = d[47:40];
        f.data_3    = d[39:32];
        f.data_4    = d[31:24];
        f.data_5    = d[23:16];
        f.data_6    = d[15:8];
        f.data_7    = d[7:0];
        f.run_last  = 1'b0;
        return f;
    endfunction

    function automatic string frame_str(out_item_t f);
        return $sformatf("id=%h len=%0d data=%h %h %h %h %h %h %h %h last=%0b",
                         f.frame_id, f.frame_len, f.data_0, f.data_1, f.data_2, f.data_3,
                         f.data_4, f.data_5, f.data_6, f.data_7, f.run_last);
    endfunction

    task automatic flush_pending_group();
        logic [15:0] start;
        logic [3:0]  fill;
        logic [63:0] d;
        fill = {1'b0, seg_fill};
        d = '0;
        if (fill != 0) begin
            start = seg_count - {12'd0, fill};
            if (start <= 255) begin
                d[63:56] = start[7:0];
                for (int j = 0; j < fill; j++) begin
                    d[55 - 8*j -: 8] = seg_group[j];
                end
                step_frames.push_back(build_frame(CODE_FILL, d, fill + 1));
            end else begin
                if (fill > 6) begin
                    fill = 4'd6;
                end
                d[63:48] = start;
                for (int j = 0; j < fill; j++) begin
                    d[47 - 8*j -: 8] = seg_group[j];
                end
                step_frames.push_back(build_frame(CODE_FILL_LONG, d, fill + 2));
            end
            seg_fill = '0;
        end
    endtask

    // Advances the segmenter by one accepted word and queues the frames it causes.
    task automatic segment_byte(input in_item_t it);
        logic        accepted;
        logic [63:0] d;
        logic [15:0] start;
        logic [2:0]  size;
        out_item_t   f;
        step_frames.delete();
        accepted = (seg_count != 16'hFFFF);
        if (seg_count == 0) begin
            seg_dest = it.dest_node;
            seg_mode = it.send_mode;
        end
        if (accepted) begin
            seg_crc = crc16_update(seg_crc, it.payload_byte);
            seg_group[seg_fill % 7] = it.payload_byte;
            seg_fill = seg_fill + 3'd1;
            seg_count = seg_count + 16'd1;
        end
        if (it.last_byte) begin
            d = '0;
            if (seg_count <= 6) begin
                d[63:48] = {own_id, seg_mode};
                for (int j = 0; j < seg_count; j++) begin
                    d[47 - 8*j -: 8] = seg_group[j];
                end
                step_frames.push_back(build_frame(CODE_SHORT, d, seg_count + 2));
            end else begin
                flush_pending_group();
                d = {own_id, seg_mode, seg_count, seg_crc, 16'h0000};
                step_frames.push_back(build_frame(CODE_PROCESS, d, 6));
            end
            seg_count = '0;
            seg_fill = '0;
            seg_crc = '0;
        end else if (accepted && seg_count >= 7) begin
            start = seg_count - {13'd0, seg_fill};
            size = (start <= 255) ? GROUP_SHORT : GROUP_LONG;
            if (seg_fill >= size) begin
                flush_pending_group();
            end
        end
        if (step_frames.size() > 0) begin
            f = step_frames.pop_back();
            f.run_last = 1'b1;
            step_frames.push_back(f);
        end
        foreach (step_frames[k]) begin
            expected_frames.push_back(step_frames[k]);
        end
    endtask

    always @(posedge aclk) begin : check_frames
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected frame: %s", frame_str(m_data));
                end
            end else begin
                want = expected_frames.pop_front();
                if (m_data.frame_id !== want.frame_id || m_data.frame_len !== want.frame_len ||
                    m_data.data_0 !== want.data_0 || m_data.data_1 !== want.data_1 ||
                    m_data.data_2 !== want.data_2 || m_data.data_3 !== want.data_3 ||
                    m_data.data_4 !== want.data_4 || m_data.data_5 !== want.data_5 ||
                    m_data.data_6 !== want.data_6 || m_data.data_7 !== want.data_7 ||
                    m_data.run_last !== want.run_last) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("frame mismatch: expected %s", frame_str(want));
                        $display("                got      %s", frame_str(m_data));
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    initial begin : drive_ready
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if ($urandom_range(1, 100) <= rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input in_item_t it);
        if ($urandom_range(1, 100) <= tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        segment_byte(it);
    endtask

    // The first eight bytes come from head, the rest are random.
    task automatic send_payload(input int len, input logic [7:0] dest, input logic [7:0] mode,
                                input logic [63:0] head);
        in_item_t it;
        for (int i = 0; i < len; i++) begin
            if (i < 8) begin
                it.payload_byte = head[63 - 8*i -: 8];
            end else begin
                it.payload_byte = 8'($urandom);
            end
            it.last_byte = (i == len - 1);
            it.dest_node = (i == 0) ? dest : 8'($urandom);
            it.send_mode = (i == 0) ? mode : 8'($urandom);
            send_byte(it);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_own_id(input logic [7:0] id);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= OWN_ID_ADDR;
        pwdata <= {24'h0, id};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        own_id = id;
    endtask

    function automatic int random_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick <= 4) begin
            return $urandom_range(7, 40);
        end
        return $urandom_range(1, 14);
    endfunction

    // Short frames at both size limits, and the first group with and without a tail.
    task automatic test_short_and_closing();
        write_own_id(8'hFF);
        send_payload(1, 8'hFF, 8'h00, 64'hFF00_0000_0000_0000);
        send_payload(6, 8'h00, 8'hFF, 64'h00FF_55AA_0180_0000);
        send_payload(7, 8'h5A, 8'hA5, {$urandom, $urandom});
        send_payload(8, 8'hC3, 8'h3C, {$urandom, $urandom});
    endtask

    // Crosses start index 255, where fill frames switch to the two-byte index.
    task automatic test_long_start_index();
        write_own_id(8'h00);
        send_payload(266, 8'($urandom), 8'($urandom), {$urandom, $urandom});
    endtask

    task automatic run_random_phase(input int n_items, input logic [7:0] id,
                                    input int tx_pct, input int rx_pct);
        int sent;
        int len;
        write_own_id(id);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            len = random_len();
            send_payload(len, 8'($urandom), 8'($urandom), {$urandom, $urandom});
            sent += len;
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(15, 8'h00, 30, 30);
        run_random_phase(10, 8'($urandom), 0, 0);
        run_random_phase(15, 8'hFF, 10, 60);
        run_random_phase(10, 8'($urandom), 60, 10);
    endtask

    // The receiver stops for a long while so the output buffer fills and s_ready drops.
    task automatic test_output_stall();
        write_own_id(8'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 300;
        send_payload(40, 8'($urandom), 8'($urandom), {$urandom, $urandom});
        send_payload(3, 8'($urandom), 8'($urandom), {$urandom, $urandom});
        send_payload(20, 8'($urandom), 8'($urandom), {$urandom, $urandom});
    endtask

    initial begin : run_tests
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_and_closing();
        test_long_start_index();
        test_random_traffic();
        test_output_stall();
        run_random_phase(30, 8'($urandom), 0, 0);
        wait_idle();
        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("can_buffer_segmenter_crc16_top test passed");
        end else begin
            $display("can_buffer_segmenter_crc16_top test failed");
        end
        $finish;
    end

endmodule
